// ----- rtl/core/dwmr_pkg.sv -----
// ----------------------------------------------------------------------------
// dwmr_pkg
// Shared constants, codes and types of the deque with match-remove.
// ----------------------------------------------------------------------------
package dwmr_pkg;

   localparam int DEPTH           = 16;
   localparam int ELEMENT_BITS    = 32;
   localparam int VALUE_BITS      = 32;
   localparam int ACTION_BITS     = 3;
   localparam int STATUS_BITS     = 3;
   localparam int COUNT_PORT_BITS = 5;
   localparam int COUNT_BITS      = $clog2(DEPTH + 1);

   typedef logic [ELEMENT_BITS-1:0] elem_type;
   typedef logic [COUNT_BITS-1:0]   count_type;

   // request actions; codes five to seven are unused
   typedef enum logic [ACTION_BITS-1:0] {
      ACT_PUSH_TAIL = 3'd0,
      ACT_PUSH_HEAD = 3'd1,
      ACT_TAKE      = 3'd2,
      ACT_PEEK      = 3'd3,
      ACT_REMOVE    = 3'd4
   } action_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK        = 3'd0,
      ST_EMPTY     = 3'd1,
      ST_NOT_FOUND = 3'd2,
      ST_ZERO      = 3'd3,
      ST_FULL      = 3'd4,
      ST_BUSY      = 3'd5
   } status_type;

   // per-cycle operation broadcast to every cell
   typedef enum logic [2:0] {
      OP_HOLD,
      OP_LOAD_TAIL,
      OP_SHIFT_BACK,
      OP_SHIFT_FRONT,
      OP_REMOVE
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      elem_type    value;
   } cell_cmd_type;

   // take the low element bits of a request word, zero-extended if wider
   function automatic elem_type to_elem(input logic [VALUE_BITS-1:0] v);
      logic [ELEMENT_BITS+VALUE_BITS-1:0] w;
      w = {{ELEMENT_BITS{1'b0}}, v};
      return w[ELEMENT_BITS-1:0];
   endfunction

   // fit an element into the response word
   function automatic logic [VALUE_BITS-1:0] from_elem(input elem_type e);
      logic [ELEMENT_BITS+VALUE_BITS-1:0] w;
      w = {{VALUE_BITS{1'b0}}, e};
      return w[VALUE_BITS-1:0];
   endfunction

   // fit the occupancy into the response count field
   function automatic logic [COUNT_PORT_BITS-1:0] to_count_port(input count_type c);
      logic [COUNT_BITS+COUNT_PORT_BITS-1:0] w;
      w = {{COUNT_PORT_BITS{1'b0}}, c};
      return w[COUNT_PORT_BITS-1:0];
   endfunction

endpackage

// ----- rtl/core/deque_with_match_remove_top.sv -----
// ----------------------------------------------------------------------------
// deque_with_match_remove_top
// Bounded deque of nonzero elements with match-remove and one held taker.
// ----------------------------------------------------------------------------
// Responses are registered: a response is valid the cycle after its request is accepted.
// Throughput: one request per cycle while the response slot is free or being taken; an insert
// that serves the held taker makes two responses and blocks new requests until the second is taken.
// The cell row does any insert, take or match-and-close-up in the cycle that accepts the request.
// Reset: synchronous, active high; clears count, held taker and responses.
// Element cells are not reset; only occupied cells are ever read.
module deque_with_match_remove_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_action,
   input  logic [31:0] req_element_value,
   input  logic        req_wait_if_empty,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_element_out,
   output logic [4:0]  rsp_entry_count,
   output logic        rsp_to_waiter,
   output logic        rsp_last_result
);
   import dwmr_pkg::*;

   count_type                   count_ff, count_in;
   logic                        waiter_ff, waiter_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [STATUS_BITS-1:0]      rsp_status_ff, rsp_status_in;
   logic [VALUE_BITS-1:0]       rsp_element_ff, rsp_element_in;
   logic [COUNT_PORT_BITS-1:0]  rsp_count_ff, rsp_count_in;
   logic                        rsp_to_waiter_ff, rsp_to_waiter_in;
   logic                        rsp_last_ff, rsp_last_in;
   logic                        sec_valid_ff, sec_valid_in;
   logic [VALUE_BITS-1:0]       sec_element_ff, sec_element_in;
   logic [COUNT_PORT_BITS-1:0]  sec_count_ff, sec_count_in;

   cell_cmd_type                cmd;
   elem_type                    value;
   elem_type                    head_data;
   logic                        found;
   logic                        accept;
   logic                        taken;

   // first response of a request, and whether it makes zero or two
   logic                        res_none;
   logic                        res_two;
   logic [STATUS_BITS-1:0]      res_status;
   logic [VALUE_BITS-1:0]       res_element;

   assign value     = to_elem(req_element_value);
   assign req_ready = !sec_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign taken     = rsp_valid_ff && rsp_ready;

   dwmr_chain u_chain (
      .clock     (clock),
      .cmd       (cmd),
      .count     (count_ff),
      .head_data (head_data),
      .found     (found)
   );

   // decode the request against the current occupancy
   always_comb begin
      cmd.op      = OP_HOLD;
      cmd.value   = value;
      count_in    = count_ff;
      waiter_in   = waiter_ff;
      res_none    = 1'b0;
      res_two     = 1'b0;
      res_status  = ST_OK;
      res_element = '0;
      case (req_action)
         ACT_PUSH_TAIL, ACT_PUSH_HEAD: begin
            if (value == '0) begin
               res_status = ST_ZERO;
            end else if (waiter_ff) begin
               waiter_in = 1'b0;
               res_two   = 1'b1;
            end else if (count_ff == COUNT_BITS'(DEPTH)) begin
               res_status = ST_FULL;
            end else begin
               cmd.op   = (req_action == ACT_PUSH_TAIL) ? OP_LOAD_TAIL : OP_SHIFT_BACK;
               count_in = count_ff + 1'b1;
            end
         end
         ACT_TAKE: begin
            if (count_ff != '0) begin
               cmd.op      = OP_SHIFT_FRONT;
               count_in    = count_ff - 1'b1;
               res_element = from_elem(head_data);
            end else if (!req_wait_if_empty) begin
               res_status = ST_EMPTY;
            end else if (waiter_ff) begin
               res_status = ST_BUSY;
            end else begin
               waiter_in = 1'b1;
               res_none  = 1'b1;
            end
         end
         ACT_PEEK: begin
            if (count_ff == '0) begin
               res_status = ST_EMPTY;
            end else begin
               res_element = from_elem(head_data);
            end
         end
         ACT_REMOVE: begin
            if (value == '0) begin
               res_status = ST_ZERO;
            end else if (found) begin
               cmd.op   = OP_REMOVE;
               count_in = count_ff - 1'b1;
            end else begin
               res_status = ST_NOT_FOUND;
            end
         end
         default: res_status = ST_OK;
      endcase
      if (!accept) begin
         cmd.op    = OP_HOLD;
         count_in  = count_ff;
         waiter_in = waiter_ff;
      end
   end

   // load, advance or drop the response slots
   always_comb begin
      rsp_valid_in     = rsp_valid_ff;
      rsp_status_in    = rsp_status_ff;
      rsp_element_in   = rsp_element_ff;
      rsp_count_in     = rsp_count_ff;
      rsp_to_waiter_in = rsp_to_waiter_ff;
      rsp_last_in      = rsp_last_ff;
      sec_valid_in     = sec_valid_ff;
      sec_element_in   = sec_element_ff;
      sec_count_in     = sec_count_ff;
      if (accept) begin
         rsp_valid_in     = !res_none;
         rsp_status_in    = res_status;
         rsp_element_in   = res_element;
         rsp_count_in     = to_count_port(count_in);
         rsp_to_waiter_in = 1'b0;
         rsp_last_in      = !res_two;
         sec_valid_in     = res_two;
         sec_element_in   = req_element_value & from_elem(value | ~value);
         sec_count_in     = to_count_port(count_in);
      end else if (taken) begin
         if (sec_valid_ff) begin
            rsp_status_in    = ST_OK;
            rsp_element_in   = sec_element_ff;
            rsp_count_in     = sec_count_ff;
            rsp_to_waiter_in = 1'b1;
            rsp_last_in      = 1'b1;
            sec_valid_in     = 1'b0;
         end else begin
            rsp_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         waiter_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         sec_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         waiter_ff    <= waiter_in;
         rsp_valid_ff <= rsp_valid_in;
         sec_valid_ff <= sec_valid_in;
      end
      rsp_status_ff    <= rsp_status_in;
      rsp_element_ff   <= rsp_element_in;
      rsp_count_ff     <= rsp_count_in;
      rsp_to_waiter_ff <= rsp_to_waiter_in;
      rsp_last_ff      <= rsp_last_in;
      sec_element_ff   <= sec_element_in;
      sec_count_ff     <= sec_count_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_element_out = rsp_element_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_to_waiter   = rsp_to_waiter_ff;
   assign rsp_last_result = rsp_last_ff;

   // the second slot only ever stands behind a waiting first response
   a_sec_behind_rsp: assert property (@(posedge clock) disable iff (reset)
      sec_valid_ff |-> rsp_valid_ff && !rsp_last_ff)
      else $error("second response held without a first response");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_BITS'(DEPTH))
      else $error("entry count beyond depth");

   // a held taker exists only while the store is empty
   a_waiter_empty: assert property (@(posedge clock) disable iff (reset)
      waiter_ff |-> count_ff == '0)
      else $error("held taker while entries are stored");

   a_waiter_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_to_waiter_ff |-> rsp_status_ff == ST_OK && rsp_last_ff)
      else $error("malformed response to held taker");

endmodule

// ----- rtl/core/dwmr_cell.sv -----
// ----------------------------------------------------------------------------
// dwmr_cell
// One storage cell of the deque: holds one element, loads from either
// neighbor or the request, and ripples the first-match flag.
// ----------------------------------------------------------------------------
module dwmr_cell (
   input  logic                  clock,
   input  dwmr_pkg::cell_cmd_type cmd,
   input  logic                  occupied,
   input  logic                  at_tail,
   input  dwmr_pkg::elem_type    head_side_data,
   input  dwmr_pkg::elem_type    tail_side_data,
   input  logic                  seen_in,
   output dwmr_pkg::elem_type    data,
   output logic                  seen_out
);
   import dwmr_pkg::*;

   elem_type data_ff;
   elem_type data_in;

   // flag this cell once a match is found here or nearer the head
   assign seen_out = seen_in | (occupied & (data_ff == cmd.value));
   assign data     = data_ff;

   // select the next element word
   always_comb begin
      data_in = data_ff;
      case (cmd.op)
         OP_LOAD_TAIL: begin
            if (at_tail) begin
               data_in = cmd.value;
            end
         end
         OP_SHIFT_BACK:  data_in = head_side_data;
         OP_SHIFT_FRONT: data_in = tail_side_data;
         OP_REMOVE: begin
            if (seen_out) begin
               data_in = tail_side_data;
            end
         end
         default: data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

// ----- rtl/core/dwmr_chain.sv -----
// ----------------------------------------------------------------------------
// dwmr_chain
// Row of deque cells from head (cell 0) to tail, linked to their neighbors.
// ----------------------------------------------------------------------------
module dwmr_chain (
   input  logic                   clock,
   input  dwmr_pkg::cell_cmd_type cmd,
   input  dwmr_pkg::count_type    count,
   output dwmr_pkg::elem_type     head_data,
   output logic                   found
);
   import dwmr_pkg::*;

   elem_type          cell_data [DEPTH];
   logic [DEPTH:0]    seen;

   assign seen[0] = 1'b0;

   // build the row
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      elem_type head_side;
      elem_type tail_side;

      if (i == 0) begin : g_head
         assign head_side = cmd.value;
      end else begin : g_mid_h
         assign head_side = cell_data[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign tail_side = cell_data[i];
      end else begin : g_mid_t
         assign tail_side = cell_data[i+1];
      end

      dwmr_cell u_cell (
         .clock          (clock),
         .cmd            (cmd),
         .occupied       (count > COUNT_BITS'(i)),
         .at_tail        (count == COUNT_BITS'(i)),
         .head_side_data (head_side),
         .tail_side_data (tail_side),
         .seen_in        (seen[i]),
         .data           (cell_data[i]),
         .seen_out       (seen[i+1])
      );
   end

   assign head_data = cell_data[0];
   assign found     = seen[DEPTH];

endmodule
